### design/rpf_pkg.sv
// ----------------------------------------------------------------------------
// rpf_pkg: shared types and constants of the range predicate row filter
// Row and result payload structs, register indexes and the discount clamp.
// ----------------------------------------------------------------------------
package rpf_pkg;

  // Field widths fixed by the row and result formats.
  localparam int unsigned DISC_W  = 14;
  localparam int unsigned QTY_W   = 16;
  localparam int unsigned ROW_W   = 32;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned ADDR_W  = 2;

  // Default sizing of the scan.
  localparam int unsigned LANES_DEF       = 8;
  localparam int unsigned BUFFER_SIZE_DEF = 1024;

  // Queue depths between the parts of the block.
  localparam int unsigned CLS_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 2;

  // Constants of the predicate.
  localparam logic [DISC_W-1:0] DISCOUNT_MAX   = DISC_W'(10000);
  localparam logic [CNT_W-1:0]  COUNT_MAX      = '1;
  localparam logic [DISC_W-1:0] DISC_LOW_RST   = DISC_W'(100);
  localparam logic [DISC_W-1:0] DISC_HIGH_RST  = DISC_W'(300);
  localparam logic [QTY_W-1:0]  QTY_LIMIT_RST  = QTY_W'(25);
  localparam logic [ROW_W-1:0]  START_ROW_RST  = '0;

  // Configuration register indexes.
  typedef enum logic [ADDR_W-1:0] {
    REG_DISC_LOW  = 2'd0,
    REG_DISC_HIGH = 2'd1,
    REG_QTY_LIMIT = 2'd2,
    REG_START_ROW = 2'd3
  } reg_idx_t;

  // One table row as it enters the block.
  typedef struct packed {
    logic [DISC_W-1:0] discount;
    logic [QTY_W-1:0]  quantity;
    logic              range_last;
  } rpf_in_t;

  // One result item.
  typedef struct packed {
    logic              match_valid;
    logic [ROW_W-1:0]  row_position;
    logic [CNT_W-1:0]  found_count;
    logic              call_end;
    logic              buffer_full;
  } rpf_out_t;

  // Classified row handed from the front to the back.
  typedef struct packed {
    logic pass;
    logic last;
  } rpf_cls_t;

  // Row counter load request from the configuration port.
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] value;
  } rpf_load_t;

  // Saturate a discount at the largest legal value.
  function automatic logic [DISC_W-1:0] clamp_discount(input logic [DISC_W-1:0] v);
    return (v > DISCOUNT_MAX) ? DISCOUNT_MAX : v;
  endfunction

endpackage

### design/range_predicate_row_filter_top.sv
// Rows pass from the classification queue through the back end into the result queue, whose head drives the outputs.
// Throughput: one row per cycle while the result queue has room, set by the back end's single counter update per row.
// A four-entry classification queue and a two-entry result queue absorb stalls.
// Reset (rst_n low, synchronous) empties both queues, loads the defaults into the
// configuration registers and clears the row counter, match count and group slot.
// ----------------------------------------------------------------------------
// range_predicate_row_filter_top: selection scan with position compaction
// Filters rows on a discount range and a quantity limit and emits the row
// numbers of passing rows, grouped into calls.
// ----------------------------------------------------------------------------
module range_predicate_row_filter_top
  import rpf_pkg::*;
#(
  parameter int unsigned LANES       = LANES_DEF,
  parameter int unsigned BUFFER_SIZE = BUFFER_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_push,
  input  rpf_in_t           in_data,
  output logic              in_full,
  input  logic              out_pop,
  output rpf_out_t          out_data,
  output logic              out_empty
);

  localparam int unsigned CLS_W = $bits(rpf_cls_t);
  localparam int unsigned RES_W = $bits(rpf_out_t);

  rpf_cls_t  cls_in, cls_out;
  rpf_load_t load;
  logic      cls_empty, cls_pop;
  logic      res_full, res_push;
  rpf_out_t  res;

  // Front end: configuration and classification.
  rpf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .row       (in_data),
    .cls       (cls_in),
    .load      (load)
  );

  // Queue between the two halves.
  rpf_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (CLS_DEPTH)
  ) u_cls_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cls_in),
    .full  (in_full),
    .pop   (cls_pop),
    .rdata (cls_out),
    .empty (cls_empty)
  );

  // Back end: numbering and call control.
  rpf_back #(
    .LANES       (LANES),
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .cls_empty (cls_empty),
    .cls       (cls_out),
    .cls_pop   (cls_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue that presents the oldest waiting result.
  rpf_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

### design/rpf_fifo.sv
// ----------------------------------------------------------------------------
// rpf_fifo: small register queue
// Flop based circular queue with a fill count; one push and one pop per cycle.
// ----------------------------------------------------------------------------
module rpf_fifo #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### design/rpf_front.sv
// ----------------------------------------------------------------------------
// rpf_front: configuration registers and row classification
// Holds the predicate bounds, evaluates each arriving row and forwards a
// row counter load when the start register is written.
// ----------------------------------------------------------------------------
module rpf_front
  import rpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  rpf_in_t           row,
  output rpf_cls_t          cls,
  output rpf_load_t         load
);

  logic [DISC_W-1:0] disc_low_r, disc_low_nxt;
  logic [DISC_W-1:0] disc_high_r, disc_high_nxt;
  logic [QTY_W-1:0]  qty_limit_r, qty_limit_nxt;
  logic [DISC_W-1:0] disc_wr;
  logic [DISC_W-1:0] disc_row;
  reg_idx_t          idx;

  assign idx     = reg_idx_t'(cfg_addr);
  assign disc_wr = clamp_discount(cfg_wdata[DISC_W-1:0]);

  // Register writes; the start register goes straight to the row counter.
  always_comb begin
    disc_low_nxt  = disc_low_r;
    disc_high_nxt = disc_high_r;
    qty_limit_nxt = qty_limit_r;
    load.valid    = 1'b0;
    load.value    = cfg_wdata[ROW_W-1:0];
    if (cfg_we) begin
      case (idx)
        REG_DISC_LOW: begin
          disc_low_nxt = disc_wr;
        end
        REG_DISC_HIGH: begin
          disc_high_nxt = disc_wr;
        end
        REG_QTY_LIMIT: begin
          qty_limit_nxt = cfg_wdata[QTY_W-1:0];
        end
        REG_START_ROW: begin
          load.valid = 1'b1;
        end
        default: begin
          load.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_low_r  <= DISC_LOW_RST;
      disc_high_r <= DISC_HIGH_RST;
      qty_limit_r <= QTY_LIMIT_RST;
    end else begin
      disc_low_r  <= disc_low_nxt;
      disc_high_r <= disc_high_nxt;
      qty_limit_r <= qty_limit_nxt;
    end
  end

  // Range test on the saturated discount and limit test on the quantity.
  assign disc_row = clamp_discount(row.discount);
  assign cls.pass = (disc_row >= disc_low_r) && (disc_row <= disc_high_r) &&
                    (row.quantity < qty_limit_r);
  assign cls.last = row.range_last;

endmodule

### design/rpf_back.sv
// ----------------------------------------------------------------------------
// rpf_back: row numbering, match counting and call termination
// Takes classified rows one per cycle while the result queue has room, keeps
// the row counter, the match count and the group slot, and builds the result items.
// ----------------------------------------------------------------------------
module rpf_back
  import rpf_pkg::*;
#(
  parameter int unsigned LANES       = LANES_DEF,
  parameter int unsigned BUFFER_SIZE = BUFFER_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  rpf_load_t load,
  input  logic      cls_empty,
  input  rpf_cls_t  cls,
  output logic      cls_pop,
  input  logic      res_full,
  output logic      res_push,
  output rpf_out_t  res
);

  localparam int unsigned SLOT_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int unsigned SUM_W  = 18;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(LANES - 1);
  localparam logic [SUM_W-1:0]  LANES_EXT = SUM_W'(LANES);
  localparam logic [SUM_W-1:0]  BUF_EXT   = SUM_W'(BUFFER_SIZE);

  logic [ROW_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic [CNT_W-1:0]  match_r, match_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  match_inc;
  logic              go;
  logic              group_done;
  logic              near_full;
  logic              end_call;

  // A row is processed when one waits and the result queue has room.
  assign go      = !cls_empty && !res_full;
  assign cls_pop = go;

  // Saturating match count including this row.
  assign match_inc  = (cls.pass && (match_r != COUNT_MAX)) ? match_r + 1'b1 : match_r;
  assign group_done = (slot_r == SLOT_LAST);
  assign near_full  = ({{(SUM_W-CNT_W){1'b0}}, match_inc} + LANES_EXT) >= BUF_EXT;
  assign end_call   = (group_done || cls.last) && (near_full || cls.last);

  // Result item for this row.
  assign res_push         = go && (cls.pass || end_call);
  assign res.match_valid  = cls.pass;
  assign res.row_position = cls.pass ? row_cnt_r : '0;
  assign res.found_count  = match_inc;
  assign res.call_end     = end_call;
  assign res.buffer_full  = end_call && near_full;

  // State update per processed row, or counter load from configuration.
  always_comb begin
    row_cnt_nxt = row_cnt_r;
    match_nxt   = match_r;
    slot_nxt    = slot_r;
    if (load.valid) begin
      row_cnt_nxt = load.value;
    end else if (go) begin
      row_cnt_nxt = row_cnt_r + 1'b1;
      match_nxt   = end_call ? '0 : match_inc;
      slot_nxt    = (group_done || cls.last) ? '0 : slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= START_ROW_RST;
      match_r   <= '0;
      slot_r    <= '0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
      match_r   <= match_nxt;
      slot_r    <= slot_nxt;
    end
  end

endmodule

### design/rpf_checker.sv
// ----------------------------------------------------------------------------
// rpf_checker: port level checks of the row filter
// Watches the result channel for well formed result items.
// ----------------------------------------------------------------------------
module rpf_checker
  import rpf_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_pop,
  input rpf_out_t out_data,
  input logic     out_empty
);

  // Nothing is offered right after reset.
  assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result offered after reset");

  // A waiting result holds until it is transferred.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed");

  // A result without a match exists only to end a call.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.match_valid || out_data.call_end))
    else $error("empty result without call end");

  // The buffer flag is given only when the call ends.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.buffer_full) |-> out_data.call_end)
    else $error("buffer full without call end");

  // A match always counts itself.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.match_valid) |-> (out_data.found_count != '0))
    else $error("match with zero count");

endmodule

bind range_predicate_row_filter_top rpf_checker u_rpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_pop   (out_pop),
  .out_data  (out_data),
  .out_empty (out_empty)
);

### sim/tb_range_predicate_row_filter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_predicate_row_filter_top: self-checking bench for the row filter
// Streams table rows into the selection scan and checks every result transfer
// against a cycle-free model of the predicate, the row numbering and the call
// bookkeeping. A short directed table covers bounds, clamping, row number wrap
// and call ends. Random phases then sweep register settings, including one long
// open-bounds call that fills the position buffer.
// ----------------------------------------------------------------------------
module tb_range_predicate_row_filter_top;
  import rpf_pkg::*;

  localparam int unsigned LANES       = LANES_DEF;
  localparam int unsigned BUFFER_SIZE = BUFFER_SIZE_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE      = 8;

  // One line of the directed table: a register write or a row, with an
  // optional hand-written result.
  typedef struct packed {
    bit                is_cfg;
    reg_idx_t          addr;
    logic [CFG_W-1:0]  wdata;
    rpf_in_t           row;
    bit                typed;
    bit                typed_has;
    rpf_out_t          typed_res;
  } scan_step_t;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_push   = 1'b0;
  rpf_in_t           in_data   = '0;
  logic              in_full;
  logic              out_pop   = 1'b0;
  rpf_out_t          out_data;
  logic              out_empty;

  // Model state: registers as the block holds them, and the scan counters.
  logic [DISC_W-1:0] lo_q;
  logic [DISC_W-1:0] hi_q;
  logic [QTY_W-1:0]  lim_q;
  logic [ROW_W-1:0]  next_row;
  int unsigned       found_q;
  int unsigned       slot_q;

  rpf_out_t          awaited_results[$];
  scan_step_t        steps[$];
  int unsigned       in_gap_pct;
  int unsigned       out_stall_pct;
  int unsigned       err_cnt;
  int unsigned       stall_cycles;

  range_predicate_row_filter_top #(
    .LANES       (LANES),
    .BUFFER_SIZE (BUFFER_SIZE)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .out_empty (out_empty)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [DISC_W-1:0] sat_discount(input logic [DISC_W-1:0] v);
    return (v > DISCOUNT_MAX) ? DISCOUNT_MAX : v;
  endfunction

  // Predicts the result of one row and advances the scan state.
  function automatic bit filter_row(input rpf_in_t row, output rpf_out_t res);
    logic [DISC_W-1:0] disc;
    logic [ROW_W-1:0]  pos;
    bit                pass;
    bit                near_full;
    bit                ends;
    disc = sat_discount(row.discount);
    pass = (disc >= lo_q) && (disc <= hi_q) && (row.quantity < lim_q);
    if (pass && found_q < COUNT_MAX) found_q++;
    pos = next_row;
    next_row = next_row + 1'b1;
    slot_q++;
    near_full = (found_q + LANES) >= BUFFER_SIZE;
    ends = 1'b0;
    if (slot_q >= LANES || row.range_last) begin
      slot_q = 0;
      ends = near_full || row.range_last;
    end
    res = '0;
    res.match_valid  = pass;
    res.row_position = pass ? pos : '0;
    res.found_count  = CNT_W'(found_q);
    res.call_end     = ends;
    res.buffer_full  = ends && near_full;
    if (ends) found_q = 0;
    return pass || ends;
  endfunction

  function automatic scan_step_t tab_row(input rpf_in_t row, input bit typed = 1'b0,
                                         input bit has = 1'b0, input rpf_out_t res = '0);
    scan_step_t s;
    s = '0;
    s.row       = row;
    s.typed     = typed;
    s.typed_has = has;
    s.typed_res = res;
    return s;
  endfunction

  function automatic scan_step_t tab_cfg(input reg_idx_t a, input logic [CFG_W-1:0] d);
    scan_step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.addr   = a;
    s.wdata  = d;
    return s;
  endfunction

  // Random row, biased toward the current bounds so that matches are common.
  function automatic rpf_in_t rand_row(input int unsigned last_pct);
    rpf_in_t     r;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45 && lo_q <= hi_q) begin
      r.discount = DISC_W'($urandom_range(hi_q, lo_q));
    end else if (sel < 55) begin
      case ($urandom_range(3))
        0: r.discount = lo_q;
        1: r.discount = hi_q;
        2: r.discount = lo_q - 1'b1;
        default: r.discount = hi_q + 1'b1;
      endcase
    end else if (sel < 70) begin
      r.discount = DISC_W'($urandom_range(16383, 10001));
    end else begin
      r.discount = DISC_W'($urandom_range(16383));
    end
    sel = $urandom_range(99);
    if (sel < 50 && lim_q != 0) begin
      r.quantity = QTY_W'($urandom_range(lim_q - 1));
    end else if (sel < 60) begin
      r.quantity = lim_q;
    end else if (sel < 65) begin
      r.quantity = '1;
    end else begin
      r.quantity = QTY_W'($urandom_range(65535));
    end
    r.range_last = ($urandom_range(99) < last_pct);
    return r;
  endfunction

  // Presents one row and returns at the edge of its transfer.
  task automatic send_row(input rpf_in_t row);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < in_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= row;
    do @(posedge clk); while (in_full);
  endtask

  // Register write. The first write of a group waits until the block is idle.
  task automatic cfg_write(input reg_idx_t a, input logic [CFG_W-1:0] d);
    if (!cfg_we) begin
      in_push <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
    case (a)
      REG_DISC_LOW:  lo_q = sat_discount(d[DISC_W-1:0]);
      REG_DISC_HIGH: hi_q = sat_discount(d[DISC_W-1:0]);
      REG_QTY_LIMIT: lim_q = d[QTY_W-1:0];
      REG_START_ROW: next_row = d[ROW_W-1:0];
      default: ;
    endcase
  endtask

  // Receiver: stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= out_stall_pct);
  end

  // Result checker: every result transfer against the oldest expectation.
  always @(posedge clk) begin : check_results
    rpf_out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: row_position %0h found_count %0d call_end %0b",
               out_data.row_position, out_data.found_count, out_data.call_end);
        err_cnt++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.match_valid !== want.match_valid) begin
          $error("match_valid: expected %0b, got %0b", want.match_valid, out_data.match_valid);
          err_cnt++;
        end
        if (out_data.row_position !== want.row_position) begin
          $error("row_position: expected %0h, got %0h",
                 want.row_position, out_data.row_position);
          err_cnt++;
        end
        if (out_data.found_count !== want.found_count) begin
          $error("found_count: expected %0d, got %0d", want.found_count, out_data.found_count);
          err_cnt++;
        end
        if (out_data.call_end !== want.call_end) begin
          $error("call_end: expected %0b, got %0b", want.call_end, out_data.call_end);
          err_cnt++;
        end
        if (out_data.buffer_full !== want.buffer_full) begin
          $error("buffer_full: expected %0b, got %0b", want.buffer_full, out_data.buffer_full);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_range_predicate_row_filter_top failed");
      $finish;
    end
  end

  initial begin : stimulus
    rpf_out_t         res;
    bit               has;
    logic [CFG_W-1:0] lo_w;
    logic [CFG_W-1:0] hi_w;
    logic [CFG_W-1:0] lim_w;
    logic [CFG_W-1:0] st_w;
    int unsigned      n_rows;
    int unsigned      sent;
    int unsigned      third;

    err_cnt       = 0;
    stall_cycles  = 0;
    in_gap_pct    = 14;
    out_stall_pct = 49;
    lo_q          = DISC_LOW_RST;
    hi_q          = DISC_HIGH_RST;
    lim_q         = QTY_LIMIT_RST;
    next_row      = START_ROW_RST;
    found_q       = 0;
    slot_q        = 0;

    // Defaults after reset: discount 100..300, quantity below 25, rows from 0.
    steps.push_back(tab_row(rpf_in_t'{14'd100, 16'd0, 1'b0}, 1, 1,
                            rpf_out_t'{1'b1, 32'd0, 11'd1, 1'b0, 1'b0}));
    steps.push_back(tab_row(rpf_in_t'{14'd300, 16'd24, 1'b0}, 1, 1,
                            rpf_out_t'{1'b1, 32'd1, 11'd2, 1'b0, 1'b0}));
    steps.push_back(tab_row(rpf_in_t'{14'd99, 16'd0, 1'b0}, 1, 0));
    steps.push_back(tab_row(rpf_in_t'{14'd301, 16'd0, 1'b0}, 1, 0));
    steps.push_back(tab_row(rpf_in_t'{14'd200, 16'd25, 1'b0}, 1, 0));
    // Oversized discount saturates to 10000 and misses the range.
    steps.push_back(tab_row(rpf_in_t'{14'h3FFF, 16'd0, 1'b0}, 1, 0));
    steps.push_back(tab_row(rpf_in_t'{14'd150, 16'hFFFF, 1'b0}, 1, 0));
    // Group closes with room in the buffer and no range end: nothing out.
    steps.push_back(tab_row(rpf_in_t'{14'd0, 16'd0, 1'b0}, 1, 0));
    steps.push_back(tab_row(rpf_in_t'{14'd200, 16'd3, 1'b1}, 1, 1,
                            rpf_out_t'{1'b1, 32'd8, 11'd3, 1'b1, 1'b0}));
    // Range end on a row that fails the predicate.
    steps.push_back(tab_row(rpf_in_t'{14'd0, 16'd0, 1'b1}, 1, 1,
                            rpf_out_t'{1'b0, 32'd0, 11'd0, 1'b1, 1'b0}));
    // Widest bounds, register clamping and row number wrap.
    steps.push_back(tab_cfg(REG_DISC_LOW, 32'hFFFF_C000));
    steps.push_back(tab_cfg(REG_DISC_HIGH, 32'h0000_3FFF));
    steps.push_back(tab_cfg(REG_QTY_LIMIT, 32'hFFFF_FFFF));
    steps.push_back(tab_cfg(REG_START_ROW, 32'hFFFF_FFFE));
    steps.push_back(tab_row(rpf_in_t'{14'd10000, 16'hFFFE, 1'b0}, 1, 1,
                            rpf_out_t'{1'b1, 32'hFFFF_FFFE, 11'd1, 1'b0, 1'b0}));
    steps.push_back(tab_row(rpf_in_t'{14'h3FFF, 16'd0, 1'b0}, 1, 1,
                            rpf_out_t'{1'b1, 32'hFFFF_FFFF, 11'd2, 1'b0, 1'b0}));
    steps.push_back(tab_row(rpf_in_t'{14'd0, 16'hFFFF, 1'b0}, 1, 0));
    steps.push_back(tab_row(rpf_in_t'{14'd0, 16'd0, 1'b1}, 1, 1,
                            rpf_out_t'{1'b1, 32'd1, 11'd3, 1'b1, 1'b0}));
    // Inverted bounds pass nothing.
    steps.push_back(tab_cfg(REG_DISC_LOW, 32'd500));
    steps.push_back(tab_cfg(REG_DISC_HIGH, 32'd400));
    steps.push_back(tab_row(rpf_in_t'{14'd450, 16'd0, 1'b1}, 1, 1,
                            rpf_out_t'{1'b0, 32'd0, 11'd0, 1'b1, 1'b0}));
    steps.push_back(tab_row(rpf_in_t'{14'd500, 16'd0, 1'b0}));
    // Zero quantity limit passes nothing; a start row write keeps the counts.
    steps.push_back(tab_cfg(REG_DISC_LOW, 32'd10000));
    steps.push_back(tab_cfg(REG_DISC_HIGH, 32'd10000));
    steps.push_back(tab_cfg(REG_QTY_LIMIT, 32'd0));
    steps.push_back(tab_cfg(REG_START_ROW, 32'h8000_0000));
    steps.push_back(tab_row(rpf_in_t'{14'd10000, 16'd0, 1'b0}));
    steps.push_back(tab_row(rpf_in_t'{14'd10000, 16'd0, 1'b1}, 1, 1,
                            rpf_out_t'{1'b0, 32'd0, 11'd0, 1'b1, 1'b0}));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        cfg_write(steps[i].addr, steps[i].wdata);
      end else begin
        send_row(steps[i].row);
        has = filter_row(steps[i].row, res);
        if (steps[i].typed) begin
          has = steps[i].typed_has;
          res = steps[i].typed_res;
        end
        if (has) awaited_results.push_back(res);
      end
    end

    // Random phases; phase 5 is one long open call that fills the buffer.
    sent  = 0;
    third = (6 * 12 + 1030) / 3;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          lo_w = 32'd0; hi_w = 32'hFFFF_FFFF; lim_w = 32'd0; st_w = $urandom();
        end
        1: begin
          lo_w = 32'd10000; hi_w = 32'd10000; lim_w = 32'h0000_FFFF; st_w = 32'hFFFF_FFE0;
        end
        2: begin
          lo_w = 32'd0; hi_w = 32'd0; lim_w = 32'd1; st_w = 32'd0;
        end
        3: begin
          lo_w  = $urandom_range(10000);
          hi_w  = $urandom_range(10000);
          lim_w = $urandom_range(65535);
          st_w  = $urandom();
        end
        5: begin
          lo_w = 32'h0000_C000; hi_w = 32'd10000; lim_w = 32'h0000_FFFF; st_w = $urandom();
        end
        default: begin
          lo_w = $urandom(); hi_w = $urandom(); lim_w = $urandom(); st_w = $urandom();
        end
      endcase
      cfg_write(REG_DISC_LOW, lo_w);
      cfg_write(REG_DISC_HIGH, hi_w);
      cfg_write(REG_QTY_LIMIT, lim_w);
      cfg_write(REG_START_ROW, st_w);
      n_rows = (p == 5) ? 1030 : 12;
      for (int k = 0; k < n_rows; k++) begin
        rpf_in_t row;
        if (sent < third) begin
          in_gap_pct = 14; out_stall_pct = 49;
        end else if (sent < 2 * third) begin
          in_gap_pct = 49; out_stall_pct = 14;
        end else begin
          in_gap_pct = 0; out_stall_pct = 0;
        end
        // In the long call, end the range only once the buffer is nearly full.
        if (p == 5) begin
          row = rand_row((found_q + LANES >= BUFFER_SIZE) ? 30 : 0);
          // An all-ones quantity never passes, so every row of the call matches.
          if (row.quantity == '1) row.quantity = '0;
        end else begin
          row = rand_row(10);
        end
        send_row(row);
        if (filter_row(row, res)) awaited_results.push_back(res);
        sent++;
      end
    end

    in_push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE + 2) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_range_predicate_row_filter_top passed");
    end else begin
      $display("tb_range_predicate_row_filter_top failed");
    end
    $finish;
  end

endmodule
